@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check b in the same cycle as a
`define ASSERT_SAME(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// check b in the cycle after a
`define ASSERT_NEXT(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

@@ sv/sdtq_pkg.sv @@
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared codes and controller/datapath interface types of the timer queue.
// ----------------------------------------------------------------------------
package sdtq_pkg;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_EXPIRE = 1'b1;

    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic load_item;
        logic calc;
        logic insert;
        logic drop;
        logic pop_emit;
        logic emit_status;
    } sdtq_cmd_t;

    typedef struct packed {
        logic is_expire;
        logic full;
        logic due;
        logic out_free;
    } sdtq_sts_t;

endpackage

@@ sv/sdtq_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdtq_ctrl
// Sequencer of the timer queue: accept, deadline add, insert or pop loop,
// status result.
// ----------------------------------------------------------------------------
module sdtq_ctrl
    import sdtq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sdtq_sts_t sts,
    output sdtq_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CALC = 5'b00010,
        ST_INS  = 5'b00100,
        ST_EXP  = 5'b01000,
        ST_STAT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = sts.is_expire ? ST_EXP : ST_INS;
            end
            ST_INS:
            begin
                cmd.insert = !sts.full;
                cmd.drop   = sts.full;
                state_next = ST_STAT;
            end
            ST_EXP:
            begin
                if (sts.due)
                begin
                    cmd.pop_emit = sts.out_free;
                end
                else
                begin
                    state_next = ST_STAT;
                end
            end
            ST_STAT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/sdtq_datapath.sv @@
// ----------------------------------------------------------------------------
// sdtq_datapath
// Sorted entry shift array, item registers, deadline adder and result register.
// ----------------------------------------------------------------------------
module sdtq_datapath
    import sdtq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sdtq_cmd_t              cmd,
    output sdtq_sts_t              sts,
    input  logic                   in_mode,
    input  logic [63:0]            in_now,
    input  logic [31:0]            in_delay,
    input  logic [HANDLE_BITS-1:0] in_handle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_kind,
    output logic [HANDLE_BITS-1:0] out_handle,
    output logic [63:0]            out_reload,
    output logic                   out_empty,
    output logic                   out_dropped,
    output logic                   out_last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                   mode_reg;
    logic [63:0]            now_reg;
    logic [31:0]            delay_reg;
    logic [HANDLE_BITS-1:0] hnd_reg;
    logic [63:0]            dl_reg;
    logic                   dropped_reg;
    logic [CNT_W-1:0]       count_reg;

    logic [63:0]            dl_mem_reg [DEPTH];
    logic [HANDLE_BITS-1:0] hd_mem_reg [DEPTH];
    logic [DEPTH-1:0]       le;

    logic                   out_valid_reg;
    logic                   out_kind_reg;
    logic [HANDLE_BITS-1:0] out_handle_reg;
    logic [63:0]            out_reload_reg;
    logic                   out_empty_reg;
    logic                   out_dropped_reg;
    logic                   out_last_reg;

    logic                   is_empty;
    logic                   out_free;

    assign is_empty = (count_reg == '0);
    assign out_free = !out_valid_reg || out_ready;

    assign sts.is_expire = (mode_reg == MODE_EXPIRE);
    assign sts.full      = (count_reg == CNT_W'(DEPTH));
    assign sts.due       = !is_empty && (dl_mem_reg[0] <= now_reg);
    assign sts.out_free  = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg  <= in_mode;
            now_reg   <= in_now;
            delay_reg <= in_delay;
            hnd_reg   <= in_handle;
        end
        if (cmd.calc)
        begin
            dl_reg <= now_reg + {32'd0, delay_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                dropped_reg <= 1'b0;
            end
            else if (cmd.drop)
            begin
                dropped_reg <= 1'b1;
            end
            if (cmd.insert)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.pop_emit)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entries at or before the new deadline stay, the new one goes after them
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_entry
        assign le[i] = (CNT_W'(i) < count_reg) && (dl_mem_reg[i] <= dl_reg);

        always_ff @(posedge clk)
        begin
            if (cmd.insert && !le[i])
            begin
                if (i == 0)
                begin
                    dl_mem_reg[i] <= dl_reg;
                    hd_mem_reg[i] <= hnd_reg;
                end
                else if (le[(i == 0) ? 0 : i - 1])
                begin
                    dl_mem_reg[i] <= dl_reg;
                    hd_mem_reg[i] <= hnd_reg;
                end
                else
                begin
                    dl_mem_reg[i] <= dl_mem_reg[(i == 0) ? 0 : i - 1];
                    hd_mem_reg[i] <= hd_mem_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (cmd.pop_emit && (i < DEPTH - 1))
            begin
                dl_mem_reg[i] <= dl_mem_reg[(i < DEPTH - 1) ? i + 1 : i];
                hd_mem_reg[i] <= hd_mem_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.pop_emit || cmd.emit_status)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop_emit)
        begin
            out_kind_reg    <= KIND_FIRED;
            out_handle_reg  <= hd_mem_reg[0];
            out_reload_reg  <= '0;
            out_empty_reg   <= 1'b0;
            out_dropped_reg <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else if (cmd.emit_status)
        begin
            out_kind_reg    <= KIND_STATUS;
            out_handle_reg  <= '0;
            out_reload_reg  <= is_empty ? 64'd0 : (dl_mem_reg[0] - now_reg);
            out_empty_reg   <= is_empty;
            out_dropped_reg <= dropped_reg;
            out_last_reg    <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_handle  = out_handle_reg;
    assign out_reload  = out_reload_reg;
    assign out_empty   = out_empty_reg;
    assign out_dropped = out_dropped_reg;
    assign out_last    = out_last_reg;

endmodule

@@ sv/sorted_deadline_timer_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// Holds up to DEPTH pending timers sorted by 64-bit deadline, earliest first.
// An insert item (tuser 0) queues entry_handle at now_ticks + delay_ticks,
// after any entry with an equal or earlier deadline, or is dropped and
// flagged when the queue is full. An expire item (tuser 1) pops every entry
// due at now_ticks, one fired report per entry, and every item ends with a
// status result (tuser 1, tlast 1) carrying the reload value or the empty
// flag. One item is worked on at a time. An expire pops its due entries one
// by one, as the entry array shifts one place per pop and each report passes
// through the single output register. The next item is accepted while the
// last status still waits to be taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_deadline_timer_queue
    import sdtq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 16
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // now_ticks, delay_ticks, entry_handle
    input  logic [((96 + HANDLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // mode
    input  logic                                        s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // fired_handle, reload_ticks, queue_empty, insert_dropped
    output logic [((66 + HANDLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // kind
    output logic                                        m_tuser,
    output logic                                        m_tlast
);

    localparam int OUT_TW = ((66 + HANDLE_BITS + 7) / 8) * 8;

    sdtq_cmd_t              cmd;
    sdtq_sts_t              sts;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [63:0]            out_reload;
    logic                   out_empty;
    logic                   out_dropped;

    sdtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sdtq_datapath #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_mode     (s_tuser),
        .in_now      (s_tdata[63:0]),
        .in_delay    (s_tdata[95:64]),
        .in_handle   (s_tdata[96 +: HANDLE_BITS]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_handle  (out_handle),
        .out_reload  (out_reload),
        .out_empty   (out_empty),
        .out_dropped (out_dropped),
        .out_last    (m_tlast)
    );

    assign m_tdata = OUT_TW'({out_dropped, out_empty, out_reload, out_handle});

    `ASSERT_NEXT(a_one_item_at_a_time, s_tvalid && s_tready, !s_tready, "item accepted twice")
    `ASSERT_SAME(a_no_insert_when_full, cmd.insert, !sts.full, "insert into full queue")
    `ASSERT_SAME(a_pop_only_due, cmd.pop_emit, sts.due && sts.out_free, "pop without due entry")
    `ASSERT_NEXT(a_status_is_last, cmd.emit_status, m_tvalid && m_tlast, "status not marked last")

endmodule
